// ===== rtl/core/pau_pkg.sv =====
// ----------------------------------------------------------------------------
// pau_pkg
// Shared types, sizes and codes for the pareto archive update block.
// ----------------------------------------------------------------------------
package pau_pkg;

   localparam int ARCHIVE_DEPTH = 64;
   localparam int RULE_BITS     = 32;
   localparam int CORRECT_BITS  = 16;

   localparam int ADDR_W = $clog2(ARCHIVE_DEPTH);
   localparam int CNT_W  = $clog2(ARCHIVE_DEPTH + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   // low bits of the port fields that the archive keeps
   localparam logic [15:0] CORRECT_MASK =
      (CORRECT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << CORRECT_BITS) - 32'd1);
   localparam logic [31:0] RULE_MASK =
      (RULE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << RULE_BITS) - 64'd1);

   // request opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // response status codes
   localparam logic [2:0] STATUS_INSERTED = 3'd0;
   localparam logic [2:0] STATUS_REJECTED = 3'd1;
   localparam logic [2:0] STATUS_DROPPED  = 3'd2;
   localparam logic [2:0] STATUS_READ     = 3'd3;
   localparam logic [2:0] STATUS_CLEARED  = 3'd4;

   typedef struct packed {
      logic [15:0]        correct;
      logic signed [5:0]  neg_rules;
      logic signed [12:0] neg_size;
   } score_type;

   typedef struct packed {
      score_type   score;
      logic [31:0] mask;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // outcome of one dominance compare
   typedef struct packed {
      logic cand_dom;
      logic entry_dom;
   } dom_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_DONE
   } state_type;

   function automatic logic [6:0] sat7(input count_type v);
      if (32'(v) > 32'd127) begin
         return 7'd127;
      end
      return 7'(v);
   endfunction

endpackage

// ===== rtl/core/pareto_archive_update.sv =====
// ----------------------------------------------------------------------------
// pareto_archive_update
// Archive of non-dominated candidates over three maximized objectives.
// ----------------------------------------------------------------------------
// usage
//   req_* channel carries one request: insert, read entry or clear.
//   rsp_* channel returns one response per insert, read or clear; an
//   unused opcode is taken and dropped without a response.
//   insert scans the archive from slot 0 with one shared dominance compare
//   and one ram read port: after an accept step each scanned entry is
//   fetched, then evaluated, and a finish step ends the request.
//   dominated entries are dropped while kept entries are copied down in
//   the same pass, so no second compaction pass runs. read goes through
//   accept, ram fetch and finish, with no fetch when the index is at or
//   past the count; clear goes through accept and finish.
//   req_stall is high from acceptance until the response is loaded into
//   the output register; a new request is taken while a response still
//   waits there, and its own finish waits until that register is free.
//   rsp_stall holds a valid response register unchanged.
//   reset clears the entry count and the control state; the ram keeps its
//   contents, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module pareto_archive_update (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_score_correct,
   input  logic [5:0]  req_score_neg_rules,
   input  logic [12:0] req_score_neg_size,
   input  logic [31:0] req_rule_mask,
   input  logic [5:0]  req_read_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_removed_count,
   output logic [6:0]  rsp_archive_count,
   output logic        rsp_read_valid,
   output logic [15:0] rsp_read_correct,
   output logic [5:0]  rsp_read_neg_rules,
   output logic [12:0] rsp_read_neg_size,
   output logic [31:0] rsp_read_mask
);
   import pau_pkg::*;

   // control state
   state_type  state_ff, state_in;
   count_type  count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // working registers of the current request
   logic [1:0] op_ff, op_in;
   entry_type  cand_ff, cand_in;
   count_type  rd_ptr_ff, rd_ptr_in;
   count_type  wr_ptr_ff, wr_ptr_in;
   count_type  removed_ff, removed_in;
   logic       rejected_ff, rejected_in;
   logic       read_hit_ff, read_hit_in;

   // response register
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_removed_ff, rsp_removed_in;
   logic [6:0]  rsp_archive_ff, rsp_archive_in;
   logic        rsp_read_valid_ff, rsp_read_valid_in;
   entry_type   rsp_entry_ff, rsp_entry_in;

   // ram and compare unit
   logic       ram_wr_en;
   addr_type   ram_wr_addr;
   entry_type  ram_wr_data;
   logic       ram_rd_en;
   addr_type   ram_rd_addr;
   entry_type  ram_rd_data;
   dom_type    dom;

   // scan scratch
   count_type  new_count;
   logic       out_free;
   logic       rejected_next;

   pau_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ARCHIVE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the single compare unit, candidate against the entry just fetched
   pau_dom_cmp u_dom_cmp (
      .cand  (cand_ff.score),
      .entry (ram_rd_data.score),
      .dom   (dom)
   );

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      op_in             = op_ff;
      cand_in           = cand_ff;
      rd_ptr_in         = rd_ptr_ff;
      wr_ptr_in         = wr_ptr_ff;
      removed_in        = removed_ff;
      rejected_in       = rejected_ff;
      read_hit_in       = read_hit_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_removed_in    = rsp_removed_ff;
      rsp_archive_in    = rsp_archive_ff;
      rsp_read_valid_in = rsp_read_valid_ff;
      rsp_entry_in      = rsp_entry_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_ptr_ff[ADDR_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_ptr_ff[ADDR_W-1:0];

      new_count     = count_ff - removed_ff;
      out_free      = !rsp_valid_ff || !rsp_stall;
      rejected_next = rejected_ff;
      req_stall     = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in                   = req_opcode;
               cand_in.score.correct   = req_score_correct & CORRECT_MASK;
               cand_in.score.neg_rules = req_score_neg_rules;
               cand_in.score.neg_size  = req_score_neg_size;
               cand_in.mask            = req_rule_mask & RULE_MASK;
               wr_ptr_in               = '0;
               removed_in              = '0;
               rejected_in             = 1'b0;
               unique case (req_opcode)
                  OP_INSERT: begin
                     rd_ptr_in = '0;
                     state_in  = (count_ff == '0) ? ST_DONE : ST_FETCH;
                  end
                  OP_READ: begin
                     // slot index reused as the read pointer
                     rd_ptr_in   = count_type'(req_read_index);
                     read_hit_in = 32'(req_read_index) < 32'(count_ff);
                     state_in    = read_hit_in ? ST_FETCH : ST_DONE;
                  end
                  OP_CLEAR: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     // unused opcode, taken and dropped
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = (op_ff == OP_INSERT) ? ST_EVAL : ST_DONE;
         end

         ST_EVAL: begin
            rd_ptr_in = rd_ptr_ff + count_type'(1);
            if (!rejected_ff && dom.cand_dom) begin
               // dominated entry is dropped, later entries close the gap
               removed_in = removed_ff + count_type'(1);
            end else begin
               ram_wr_en = 1'b1;
               wr_ptr_in = wr_ptr_ff + count_type'(1);
               if (!rejected_ff && dom.entry_dom) begin
                  rejected_next = 1'b1;
               end
            end
            rejected_in = rejected_next;
            // after a rejection with nothing removed the rest is already in place
            if (rejected_next && (removed_ff == '0)) begin
               state_in = ST_DONE;
            end else if (rd_ptr_in < count_ff) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               state_in          = ST_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_removed_in    = 7'd0;
               rsp_read_valid_in = 1'b0;
               rsp_entry_in      = '0;
               unique case (op_ff)
                  OP_INSERT: begin
                     rsp_removed_in = sat7(removed_ff);
                     if (rejected_ff) begin
                        rsp_status_in = STATUS_REJECTED;
                        count_in      = new_count;
                     end else if (32'(new_count) < ARCHIVE_DEPTH) begin
                        // append behind the kept entries
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = new_count[ADDR_W-1:0];
                        ram_wr_data   = cand_ff;
                        rsp_status_in = STATUS_INSERTED;
                        count_in      = new_count + count_type'(1);
                     end else begin
                        rsp_status_in = STATUS_DROPPED;
                        count_in      = new_count;
                     end
                  end
                  OP_READ: begin
                     rsp_status_in     = STATUS_READ;
                     rsp_read_valid_in = read_hit_ff;
                     if (read_hit_ff) begin
                        rsp_entry_in = ram_rd_data;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_CLEARED;
                     count_in      = '0;
                  end
               endcase
               rsp_archive_in = sat7(count_in);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      cand_ff           <= cand_in;
      rd_ptr_ff         <= rd_ptr_in;
      wr_ptr_ff         <= wr_ptr_in;
      removed_ff        <= removed_in;
      rejected_ff       <= rejected_in;
      read_hit_ff       <= read_hit_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_removed_ff    <= rsp_removed_in;
      rsp_archive_ff    <= rsp_archive_in;
      rsp_read_valid_ff <= rsp_read_valid_in;
      rsp_entry_ff      <= rsp_entry_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_count  = rsp_removed_ff;
   assign rsp_archive_count  = rsp_archive_ff;
   assign rsp_read_valid     = rsp_read_valid_ff;
   assign rsp_read_correct   = rsp_entry_ff.score.correct;
   assign rsp_read_neg_rules = rsp_entry_ff.score.neg_rules;
   assign rsp_read_neg_size  = rsp_entry_ff.score.neg_size;
   assign rsp_read_mask      = rsp_entry_ff.mask;

endmodule

// ===== rtl/core/pau_ram.sv =====
// ----------------------------------------------------------------------------
// pau_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pau_dom_cmp.sv =====
// ----------------------------------------------------------------------------
// pau_dom_cmp
// Three objective dominance compare, all objectives maximized.
// ----------------------------------------------------------------------------
module pau_dom_cmp (
   input  pau_pkg::score_type cand,
   input  pau_pkg::score_type entry,
   output pau_pkg::dom_type   dom
);
   import pau_pkg::*;

   logic [2:0] gt;
   logic [2:0] lt;

   always_comb begin
      gt[0] = cand.correct > entry.correct;
      lt[0] = cand.correct < entry.correct;
      gt[1] = $signed(cand.neg_rules) > $signed(entry.neg_rules);
      lt[1] = $signed(cand.neg_rules) < $signed(entry.neg_rules);
      gt[2] = $signed(cand.neg_size) > $signed(entry.neg_size);
      lt[2] = $signed(cand.neg_size) < $signed(entry.neg_size);
      // equal scores dominate neither way
      dom.cand_dom  = (lt == 3'b000) && (gt != 3'b000);
      dom.entry_dom = (gt == 3'b000) && (lt != 3'b000);
   end

endmodule

// ===== rtl/core/pau_checker.sv =====
// ----------------------------------------------------------------------------
// pau_checker
// Port level checks of the pareto archive update block, bound to the top.
// ----------------------------------------------------------------------------
module pau_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [6:0]  rsp_removed_count,
   input logic [6:0]  rsp_archive_count,
   input logic        rsp_read_valid
);
   import pau_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_archive_count))
      else $error("response changed while stalled");

   // the archive never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_archive_count) <= ARCHIVE_DEPTH)
      else $error("archive count beyond depth");

   // only a read reports a valid entry
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_status == STATUS_READ)
      else $error("read valid on a non-read response");

   // a clear empties the archive and removes nothing
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CLEARED
         |-> rsp_archive_count == 7'd0 && rsp_removed_count == 7'd0)
      else $error("clear left entries");

   // a stored candidate leaves at least one entry
   a_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INSERTED |-> rsp_archive_count != 7'd0)
      else $error("insert left an empty archive");

endmodule

bind pareto_archive_update pau_checker u_pau_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_removed_count (rsp_removed_count),
   .rsp_archive_count (rsp_archive_count),
   .rsp_read_valid    (rsp_read_valid)
);

// ===== tb/pareto_archive_checker.sv =====
// ----------------------------------------------------------------------------
// pareto_archive_checker
// Watches both channels of the pareto archive block, keeps its own copy of
// the archive, works out the response of every accepted request and compares
// each accepted response field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module pareto_archive_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_score_correct,
   input  logic [5:0]  req_score_neg_rules,
   input  logic [12:0] req_score_neg_size,
   input  logic [31:0] req_rule_mask,
   input  logic [5:0]  req_read_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [6:0]  rsp_removed_count,
   input  logic [6:0]  rsp_archive_count,
   input  logic        rsp_read_valid,
   input  logic [15:0] rsp_read_correct,
   input  logic [5:0]  rsp_read_neg_rules,
   input  logic [12:0] rsp_read_neg_size,
   input  logic [31:0] rsp_read_mask,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          drop_count,
   output int          reject_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pau_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  removed;
      logic [6:0]  held;
      logic        rd_valid;
      logic [15:0] rd_correct;
      logic [5:0]  rd_neg_rules;
      logic [12:0] rd_neg_size;
      logic [31:0] rd_mask;
   } response_type;

   score_type    held_score [ARCHIVE_DEPTH];
   logic [31:0]  held_mask  [ARCHIVE_DEPTH];
   int           held_len;
   response_type due_responses [$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      checked      = 0;
      drop_count   = 0;
      reject_count = 0;
      held_len     = 0;
      for (int i = 0; i < ARCHIVE_DEPTH; i++) begin
         held_score[i] = '0;
         held_mask[i]  = '0;
      end
   end

   // 1: a dominates b, -1: b dominates a, 0: neither (equal included)
   function automatic int dominance(input score_type a, input score_type b);
      logic better;
      logic worse;
      better = 1'b0;
      worse  = 1'b0;
      if (a.correct > b.correct) better = 1'b1;
      if (a.correct < b.correct) worse = 1'b1;
      if ($signed(a.neg_rules) > $signed(b.neg_rules)) better = 1'b1;
      if ($signed(a.neg_rules) < $signed(b.neg_rules)) worse = 1'b1;
      if ($signed(a.neg_size) > $signed(b.neg_size)) better = 1'b1;
      if ($signed(a.neg_size) < $signed(b.neg_size)) worse = 1'b1;
      if (better && !worse) return 1;
      if (worse && !better) return -1;
      return 0;
   endfunction

   task automatic archive_step(input logic [1:0] op, input logic [15:0] corr,
                               input logic [5:0] nrules, input logic [12:0] nsize,
                               input logic [31:0] mask, input logic [5:0] idx);
      response_type want;
      score_type    cand;
      int           j;
      int           removed;
      int           verdict;
      logic         beaten;
      want = '0;
      if (op == OP_INSERT) begin
         cand.correct   = corr & CORRECT_MASK;
         cand.neg_rules = nrules;
         cand.neg_size  = nsize;
         j       = 0;
         removed = 0;
         beaten  = 1'b0;
         while (j < held_len && !beaten) begin
            verdict = dominance(cand, held_score[j]);
            if (verdict > 0) begin
               for (int k = j; k + 1 < held_len; k++) begin
                  held_score[k] = held_score[k + 1];
                  held_mask[k]  = held_mask[k + 1];
               end
               held_len--;
               removed++;
            end else if (verdict < 0) begin
               beaten = 1'b1;
            end else begin
               j++;
            end
         end
         if (beaten) begin
            want.status = STATUS_REJECTED;
         end else if (held_len < ARCHIVE_DEPTH) begin
            held_score[held_len] = cand;
            held_mask[held_len]  = mask & RULE_MASK;
            held_len++;
            want.status = STATUS_INSERTED;
         end else begin
            want.status = STATUS_DROPPED;
         end
         want.removed = 7'(removed);
         want.held    = 7'(held_len);
         due_responses = {due_responses, want};
      end else if (op == OP_READ) begin
         want.status = STATUS_READ;
         want.held   = 7'(held_len);
         if (int'(idx) < held_len) begin
            want.rd_valid     = 1'b1;
            want.rd_correct   = held_score[idx].correct;
            want.rd_neg_rules = held_score[idx].neg_rules;
            want.rd_neg_size  = held_score[idx].neg_size;
            want.rd_mask      = held_mask[idx];
         end
         due_responses = {due_responses, want};
      end else if (op == OP_CLEAR) begin
         held_len    = 0;
         want.status = STATUS_CLEARED;
         due_responses = {due_responses, want};
      end
      // unused opcode: taken, no response
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      fail_count++;
      $display("mismatch at %0t ns, response %0d: %s got 0x%0h expected 0x%0h",
               $time, checked, what, got, want);
   endtask

   task automatic check_response();
      response_type want;
      if (due_responses.size() == 0) begin
         report("response with none due", 32'(rsp_status), 32'd0);
         return;
      end
      want = due_responses.pop_front();
      if (rsp_status !== want.status)
         report("status", 32'(rsp_status), 32'(want.status));
      if (rsp_removed_count !== want.removed)
         report("removed_count", 32'(rsp_removed_count), 32'(want.removed));
      if (rsp_archive_count !== want.held)
         report("archive_count", 32'(rsp_archive_count), 32'(want.held));
      if (rsp_read_valid !== want.rd_valid)
         report("read_valid", 32'(rsp_read_valid), 32'(want.rd_valid));
      if (rsp_read_correct !== want.rd_correct)
         report("read_correct", 32'(rsp_read_correct), 32'(want.rd_correct));
      if (rsp_read_neg_rules !== want.rd_neg_rules)
         report("read_neg_rules", 32'(rsp_read_neg_rules), 32'(want.rd_neg_rules));
      if (rsp_read_neg_size !== want.rd_neg_size)
         report("read_neg_size", 32'(rsp_read_neg_size), 32'(want.rd_neg_size));
      if (rsp_read_mask !== want.rd_mask)
         report("read_mask", rsp_read_mask, want.rd_mask);
      if (want.status == STATUS_DROPPED) drop_count++;
      if (want.status == STATUS_REJECTED) reject_count++;
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_len = 0;
         due_responses.delete();
      end else begin
         if (req_valid && !req_stall) begin
            archive_step(req_opcode, req_score_correct, req_score_neg_rules,
                         req_score_neg_size, req_rule_mask, req_read_index);
         end
         if (rsp_valid && !rsp_stall) begin
            check_response();
         end
      end
      pending = due_responses.size();
   end

endmodule

// ===== tb/pareto_archive_update_tb.sv =====
// ----------------------------------------------------------------------------
// pareto_archive_update_tb
// Stimulus and verdict for the pareto archive block: a directed opening,
// full-archive sequences and a long random run under four idle/stall mixes,
// with all prediction and comparison done by the checker beside the block.
// ----------------------------------------------------------------------------
module pareto_archive_update_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pau_pkg::*;

   localparam int TOTAL_ITEMS = 1900;  // counted requests, unused opcodes excluded
   localparam int QUIET_LIMIT = 4000;  // cycles with no handshake on either channel
   localparam int DRAIN       = 400;   // drain wait, leave room past a full archive scan
   localparam int PHASE_LEN   = 120;   // requests per idle/stall mix

   // the one opcode the block takes and drops
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // idle and stall mixes: none, sender idle, receiver stalling, both
   localparam int IDLE_MIX  [4] = '{0, 79, 0, 28};
   localparam int STALL_MIX [4] = '{0, 0, 79, 28};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [15:0] req_score_correct = '0;
   logic [5:0]  req_score_neg_rules = '0;
   logic [12:0] req_score_neg_size = '0;
   logic [31:0] req_rule_mask = '0;
   logic [5:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_removed_count;
   logic [6:0]  rsp_archive_count;
   logic        rsp_read_valid;
   logic [15:0] rsp_read_correct;
   logic [5:0]  rsp_read_neg_rules;
   logic [12:0] rsp_read_neg_size;
   logic [31:0] rsp_read_mask;

   int fail_count;
   int pending;
   int checked;
   int drop_count;
   int reject_count;

   // stimulus bookkeeping
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   n_items = 0;
   int   n_insert = 0;
   int   n_read = 0;
   int   n_clear = 0;
   int   n_unused = 0;
   int   quiet_cycles = 0;
   logic req_taken = 1'b0;

   // scores of the last insert, reused to make equal-score candidates
   logic [15:0] last_correct = '0;
   logic [5:0]  last_neg_rules = '0;
   logic [12:0] last_neg_size = '0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   pareto_archive_update dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_score_correct   (req_score_correct),
      .req_score_neg_rules (req_score_neg_rules),
      .req_score_neg_size  (req_score_neg_size),
      .req_rule_mask       (req_rule_mask),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_removed_count   (rsp_removed_count),
      .rsp_archive_count   (rsp_archive_count),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_read_correct    (rsp_read_correct),
      .rsp_read_neg_rules  (rsp_read_neg_rules),
      .rsp_read_neg_size   (rsp_read_neg_size),
      .rsp_read_mask       (rsp_read_mask)
   );

   pareto_archive_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_score_correct   (req_score_correct),
      .req_score_neg_rules (req_score_neg_rules),
      .req_score_neg_size  (req_score_neg_size),
      .req_rule_mask       (req_rule_mask),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_removed_count   (rsp_removed_count),
      .rsp_archive_count   (rsp_archive_count),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_read_correct    (rsp_read_correct),
      .rsp_read_neg_rules  (rsp_read_neg_rules),
      .rsp_read_neg_size   (rsp_read_neg_size),
      .rsp_read_mask       (rsp_read_mask),
      .fail_count          (fail_count),
      .pending             (pending),
      .checked             (checked),
      .drop_count          (drop_count),
      .reject_count        (reject_count)
   );

   // request acceptance seen at the edge, read back by the driver at the next fall
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // receiver stalls at random, rate set by the current mix
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog: a hung block or a lost response stops the run here
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d responses due",
                  quiet_cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // present one request and hold it until taken; entered and left at a falling edge
   task automatic send_req(input logic [1:0] op, input logic [15:0] corr,
                           input logic [5:0] nrules, input logic [12:0] nsize,
                           input logic [31:0] mask, input logic [5:0] idx);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode          <= op;
      req_score_correct   <= corr;
      req_score_neg_rules <= nrules;
      req_score_neg_size  <= nsize;
      req_rule_mask       <= mask;
      req_read_index      <= idx;
      req_valid           <= 1'b1;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
      case (op)
         OP_INSERT: n_insert++;
         OP_READ:   n_read++;
         OP_CLEAR:  n_clear++;
         default:   n_unused++;
      endcase
      if (op != OP_UNUSED) n_items++;
   endtask

   function automatic logic [31:0] any_mask();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return 32'($urandom);
      endcase
   endfunction

   task automatic do_insert(input logic [15:0] corr, input logic [5:0] nrules,
                            input logic [12:0] nsize, input logic [31:0] mask);
      last_correct   = corr;
      last_neg_rules = nrules;
      last_neg_size  = nsize;
      // read index is a don't-care here, keep it moving
      send_req(OP_INSERT, corr, nrules, nsize, mask, 6'($urandom));
   endtask

   task automatic do_read(input logic [5:0] idx);
      send_req(OP_READ, 16'($urandom), 6'($urandom), 13'($urandom), 32'($urandom), idx);
   endtask

   task automatic do_clear();
      send_req(OP_CLEAR, 16'($urandom), 6'($urandom), 13'($urandom), 32'($urandom),
               6'($urandom));
   endtask

   task automatic do_unused();
      send_req(OP_UNUSED, 16'($urandom), 6'($urandom), 13'($urandom), 32'($urandom),
               6'($urandom));
   endtask

   // clear, then a front of mutually non-dominated points: correct rises while
   // the antecedent size gets worse, rule count fixed; past 64 the archive is full
   task automatic fill_front(input int points, input int base_c, input int c_step,
                             input int r_val, input int s_step);
      do_clear();
      for (int i = 0; i < points; i++) begin
         do_insert(16'(base_c + i * c_step), 6'(r_val), 13'(-(i * s_step)), any_mask());
      end
   endtask

   initial begin
      int          pick;
      int          points;
      int          base_c;
      int          c_step;
      int          r_val;
      int          s_step;
      int          phase;
      logic [15:0] corr;
      logic [5:0]  nrules;
      logic [12:0] nsize;

      // synchronous reset, released at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---------------- directed opening ----------------
      idle_pct  = IDLE_MIX[3];
      stall_pct = STALL_MIX[3];
      do_read(6'd0);                                         // read of an empty archive
      do_unused();                                           // unused opcode, no response
      do_clear();
      do_insert(16'd100, 6'(-5), 13'(-50), 32'h0000_0000);
      do_insert(16'd100, 6'(-5), 13'(-50), 32'hFFFF_FFFF);   // equal scores, both kept
      do_read(6'd1);
      do_insert(16'd50, 6'(-10), 13'(-100), 32'h1234_5678);  // dominated, rejected
      do_insert(16'd200, 6'(-1), 13'(-10), 32'hA5A5_A5A5);   // removes both equal entries
      do_read(6'd0);
      do_read(6'd63);                                        // index past the count
      do_insert(16'hFFFF, 6'h00, 13'h0000, 32'hFFFF_FFFF);   // top correct score, zero in both signed fields
      do_insert(16'h0000, 6'h20, 13'h1000, 32'h0000_0000);   // worst scores, rejected
      do_insert(16'h0000, 6'h1F, 13'h0FFF, 32'h8000_0001);   // positive codes in signed fields
      do_insert(16'hFFFF, 6'h1F, 13'h0FFF, 32'h7FFF_FFFE);   // beats both entries
      do_read(6'd0);
      do_clear();
      do_read(6'd0);                                         // cleared, nothing readable
      do_unused();

      // full archive: overflow drop, then one candidate that removes all 64
      fill_front(64, 1000, 3, -7, 50);
      do_insert(16'd1000 + 16'd192, 6'(-7), 13'(-4000), 32'h0F0F_0F0F);
      do_read(6'd63);
      do_insert(16'hFFFF, 6'h00, 13'h0000, 32'h5555_AAAA);
      // refill past the top, then reject and partial removal while full
      fill_front(70, 1000, 3, -7, 50);
      do_insert(16'd1000, 6'(-7), 13'(-4095), 32'h0000_FFFF);
      do_insert(16'd1015, 6'(-7), 13'h0000, 32'hFFFF_0000);   // beats the first six
      do_read(6'd58);

      // ---------------- random part ----------------
      while (n_items < TOTAL_ITEMS) begin
         phase     = (n_items / PHASE_LEN) % 4;
         idle_pct  = IDLE_MIX[phase];
         stall_pct = STALL_MIX[phase];
         pick      = $urandom_range(99);
         if (pick < 3) begin
            // well-formed front, at times past full, sometimes cut down by a dominator
            points = $urandom_range(30, 70);
            base_c = $urandom_range(0, 60000);
            c_step = $urandom_range(1, 8);
            r_val  = -int'($urandom_range(0, 32));
            s_step = $urandom_range(1, 58);
            fill_front(points, base_c, c_step, r_val, s_step);
            if ($urandom_range(1)) begin
               pick = $urandom_range(0, points - 1);
               do_insert(16'(base_c + pick * c_step), 6'(r_val), 13'h0000, any_mask());
            end
         end else if (pick < 63) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               // small box, lots of dominance both ways
               corr   = 16'($urandom_range(0, 31));
               nrules = 6'(-int'($urandom_range(0, 3)));
               nsize  = 13'(-int'($urandom_range(0, 31)));
            end else if (pick < 60) begin
               corr   = 16'($urandom);
               nrules = 6'($urandom);
               nsize  = 13'($urandom);
            end else if (pick < 75) begin
               corr   = last_correct;
               nrules = last_neg_rules;
               nsize  = last_neg_size;
            end else if (pick < 90) begin
               case ($urandom_range(2))
                  0:       corr = 16'h0000;
                  1:       corr = 16'hFFFF;
                  default: corr = 16'($urandom);
               endcase
               case ($urandom_range(3))
                  0:       nrules = 6'h20;
                  1:       nrules = 6'h00;
                  2:       nrules = 6'h1F;
                  default: nrules = 6'($urandom);
               endcase
               case ($urandom_range(3))
                  0:       nsize = 13'h1000;
                  1:       nsize = 13'h0000;
                  2:       nsize = 13'h0FFF;
                  default: nsize = 13'($urandom);
               endcase
            end else begin
               corr   = 16'($urandom);
               nrules = 6'(-int'($urandom_range(0, 32)));
               nsize  = 13'(-int'($urandom_range(0, 4096)));
            end
            do_insert(corr, nrules, nsize, any_mask());
         end else if (pick < 90) begin
            // mostly low slots, where the archive usually has entries
            if ($urandom_range(9) < 7) do_read(6'($urandom_range(0, 15)));
            else do_read(6'($urandom));
         end else if (pick < 94) begin
            do_clear();
         end else begin
            do_unused();
         end
      end
      req_valid <= 1'b0;

      // wait for every due response, then give a trailing unused opcode time to finish
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      $display("requests: %0d inserts, %0d reads, %0d clears, %0d unused opcodes",
               n_insert, n_read, n_clear, n_unused);
      $display("responses checked: %0d (%0d full drops, %0d rejections), %0d mismatches",
               checked, drop_count, reject_count, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pau_pkg.sv
rtl/core/pau_ram.sv
rtl/core/pau_dom_cmp.sv
rtl/core/pareto_archive_update.sv
rtl/core/pau_checker.sv
tb/pareto_archive_checker.sv
tb/pareto_archive_update_tb.sv
